>>> rtl/core/lfu_cache_macros.svh
// Assertion macros shared by the cache modules.
`ifndef LFU_CACHE_MACROS_SVH
`define LFU_CACHE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define LFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu_cache assertion failed");
// Next-cycle implication.
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu_cache assertion failed");
`else
`define LFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W     = $clog2(ENTRIES + 1);
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 32;
    localparam int STAMP_W   = 64;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 2;

    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [CAP_W-1:0]   CAP_RESET     = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

    typedef struct packed {
        logic                     func;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/lfu_ram.sv
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/lfu_ctrl.sv
`default_nettype none

`include "lfu_cache_macros.svh"

module lfu_ctrl import lfu_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SETTLE = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.start   = 1'b0;
        o_cmd.scan    = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // The first entry read goes out in the cycle the beat is taken.
                if (accept) begin
                    o_cmd.start = 1'b1;
                    o_cmd.scan  = 1'b1;
                    n_state     = i_status.scan_last ? S_SETTLE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LFU_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)

endmodule

`default_nettype wire

>>> rtl/core/lfu_dp.sv
`default_nettype none

`include "lfu_cache_macros.svh"

module lfu_dp import lfu_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire t_req             i_req,
    input  wire logic [CAP_W-1:0] i_capacity,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rsp                  o_out_data
);

    // Request and scan trackers.
    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;
    logic               r_eval;
    logic [IDX_W-1:0]   r_eval_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_match_idx;
    logic [DATA_W-1:0]  r_match_data;
    logic [CNT_W-1:0]   r_match_count;
    logic               r_have_vic;
    logic [IDX_W-1:0]   r_vic_idx;
    logic [CNT_W-1:0]   r_vic_count;
    logic [STAMP_W-1:0] r_vic_stamp;
    logic               r_have_free;
    logic [IDX_W-1:0]   r_free_idx;

    // Cache state outside the entry RAM.
    logic [ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0]   r_occ;
    logic [STAMP_W-1:0] r_stamp;

    logic               r_out_valid;
    t_rsp               r_out_data;

    logic [ENTRY_W-1:0] rdata;
    t_entry             ent;
    logic               ent_valid;
    logic               hit_now;
    logic               vic_now;
    logic               free_now;

    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   occ_ext;
    logic               full;
    logic [CNT_W-1:0]   inc_count;
    logic               wr;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    logic               set_valid;
    logic               occ_inc;
    t_rsp               rsp;
    logic               ram_we;

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign ent = t_entry'(rdata);

    assign o_status.scan_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

    // Each cycle looks at the entry read in the previous cycle.
    always_comb begin
        ent_valid = r_eval && r_valid[r_eval_idx];
        hit_now   = ent_valid && !r_found && (ent.key == r_req.key);
        // Count and stamp form one rank; strict less keeps the lowest index on ties.
        vic_now   = ent_valid && (!r_have_vic ||
                    ({ent.count, ent.stamp} < {r_vic_count, r_vic_stamp}));
        free_now  = r_eval && !r_valid[r_eval_idx] && !r_have_free;
    end

    always_comb begin
        cap_ext   = CMP_W'(i_capacity);
        cap_eff   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
        occ_ext   = CMP_W'(r_occ);
        full      = (occ_ext >= cap_eff);
        inc_count = (r_match_count == CNT_MAX) ? r_match_count : r_match_count + 1'b1;

        wr          = 1'b0;
        waddr       = r_match_idx;
        wdata.key   = r_req.key;
        wdata.data  = r_req.value;
        wdata.count = inc_count;
        wdata.stamp = r_stamp;
        set_valid   = 1'b0;
        occ_inc     = 1'b0;
        rsp.hit        = 1'b0;
        rsp.read_value = '0;

        if (r_req.func == FUNC_GET) begin
            if (r_found) begin
                wr             = 1'b1;
                wdata.data     = r_match_data;
                rsp.hit        = 1'b1;
                rsp.read_value = r_match_data;
            end else begin
                rsp.read_value = MISS_VALUE;
            end
        end else if (cap_eff != '0) begin
            wr = 1'b1;
            if (!r_found) begin
                // A full store reuses the victim's slot, so occupancy holds.
                waddr       = full ? r_vic_idx : r_free_idx;
                wdata.count = CNT_W'(1);
                set_valid   = 1'b1;
                occ_inc     = !full;
            end
        end
    end

    assign ram_we = i_cmd.commit && wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_eval      <= 1'b0;
            r_found     <= 1'b0;
            r_have_vic  <= 1'b0;
            r_have_free <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_eval <= i_cmd.scan;
            if (i_cmd.scan) begin
                r_idx <= o_status.scan_last ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.start) begin
                r_found     <= 1'b0;
                r_have_vic  <= 1'b0;
                r_have_free <= 1'b0;
            end else begin
                if (hit_now) begin
                    r_found <= 1'b1;
                end
                if (vic_now) begin
                    r_have_vic <= 1'b1;
                end
                if (free_now) begin
                    r_have_free <= 1'b1;
                end
            end
            if (ram_we) begin
                r_stamp <= r_stamp + 1'b1;
            end
            if (i_cmd.commit && set_valid) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_cmd.commit && occ_inc) begin
                r_occ <= r_occ + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_idx;
        if (i_cmd.start) begin
            r_req <= i_req;
        end
        if (hit_now) begin
            r_match_idx   <= r_eval_idx;
            r_match_data  <= ent.data;
            r_match_count <= ent.count;
        end
        if (vic_now) begin
            r_vic_idx   <= r_eval_idx;
            r_vic_count <= ent.count;
            r_vic_stamp <= ent.stamp;
        end
        if (free_now) begin
            r_free_idx <= r_eval_idx;
        end
        if (i_cmd.commit) begin
            r_out_data <= rsp;
        end
    end

    `LFU_ASSERT_IMPL(a_occ_matches_valid, i_clk, i_rst_n, 1'b1, int'(r_occ) == $countones(r_valid))
    `LFU_ASSERT_NEXT(a_commit_loads_out, i_clk, i_rst_n, i_cmd.commit, r_out_valid)
    `LFU_ASSERT_NEXT(a_stamp_only_on_commit, i_clk, i_rst_n, !i_cmd.commit, $stable(r_stamp))

endmodule

`default_nettype wire

>>> rtl/core/lfu_cache.sv
`default_nettype none

// Fully associative 16-entry key/value cache with least-frequently-used
// replacement: a get returns the stored value (or -1 on a miss), a put updates
// or inserts unless capacity is 0, evicting the entry with the lowest use count
// and then the oldest stamp when the store holds capacity entries or more. Every
// input beat yields exactly one result beat. The entries sit in a simple
// dual-port RAM (one write port, one registered read port), and the scan reads
// one entry per cycle, the first read overlapping the accept cycle; a settle
// state then waits for the last read data, and a commit state writes the entry
// back and loads the result register. The commit waits while an earlier
// result beat is still stalled at the output, which lengthens the item by
// that wait. A new beat is accepted as soon as the commit is done, even while
// the previous result is still stalled at the output. Reset clears the valid
// map at once, so no clearing pass follows reset. The capacity register sits
// at byte address 0 and should be written only while the cache is idle.
module lfu_cache import lfu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_req               i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_rsp                    o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]   pwdata,
    output logic      [APB_W-1:0]   prdata,
    output logic                    pready
);

    logic [CAP_W-1:0] r_capacity;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {{(APB_W - CAP_W){1'b0}}, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    lfu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req       (i_in_data),
        .i_capacity  (r_capacity),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> sim/tb_lfu_cache.sv
module tb_lfu_cache;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int KEY_POOL         = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_req               i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_rsp               o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    lfu_cache uut (.*);

    // Shadow copy of the cache contents.
    logic               shadow_valid [ENTRIES];
    logic [KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [DATA_W-1:0]  shadow_data  [ENTRIES];
    logic [CNT_W-1:0]   shadow_uses  [ENTRIES];
    logic [STAMP_W-1:0] shadow_stamp [ENTRIES];
    logic [STAMP_W-1:0] next_stamp;
    int                 held;
    logic [CAP_W-1:0]   capacity_reg;

    t_req pending_requests [$];
    t_rsp expected_replies [$];
    t_rsp want;
    logic req_taken = 1'b0;
    int   errors = 0;
    int   cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void refresh_entry(input int idx);
        if (shadow_uses[idx] != CNT_MAX)
            shadow_uses[idx] = shadow_uses[idx] + 1'b1;
        shadow_stamp[idx] = next_stamp;
        next_stamp = next_stamp + 1'b1;
    endfunction

    function automatic t_rsp predict_reply(input t_req req);
        t_rsp rsp;
        int   slot;
        int   limit;
        int   i;
        rsp.hit = 1'b0;
        rsp.read_value = '0;
        slot = -1;
        limit = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
        for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == req.key)
                slot = i;
        if (req.func == FUNC_GET) begin
            if (slot >= 0) begin
                rsp.hit = 1'b1;
                rsp.read_value = shadow_data[slot];
                refresh_entry(slot);
            end else begin
                rsp.read_value = MISS_VALUE;
            end
            return rsp;
        end
        if (limit == 0)
            return rsp;
        if (slot >= 0) begin
            shadow_data[slot] = req.value;
            refresh_entry(slot);
            return rsp;
        end
        // A full store gives up exactly one entry, even when capacity has
        // dropped well below the current occupancy.
        if (held >= limit) begin
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (slot < 0 || shadow_uses[i] < shadow_uses[slot] ||
                    (shadow_uses[i] == shadow_uses[slot] &&
                     shadow_stamp[i] < shadow_stamp[slot])))
                    slot = i;
            if (slot >= 0) begin
                shadow_valid[slot] = 1'b0;
                held--;
            end
        end
        if (slot < 0)
            for (i = 0; i < ENTRIES; i++)
                if (slot < 0 && !shadow_valid[i])
                    slot = i;
        if (slot >= 0) begin
            shadow_valid[slot] = 1'b1;
            shadow_key[slot] = req.key;
            shadow_data[slot] = req.value;
            shadow_uses[slot] = 1;
            shadow_stamp[slot] = next_stamp;
            next_stamp = next_stamp + 1'b1;
            held++;
        end
        return rsp;
    endfunction

    function automatic void queue_item(input logic func, input logic [KEY_W-1:0] key,
                                       input logic [DATA_W-1:0] value);
        t_req req;
        req.func = func;
        req.key = key;
        req.value = value;
        pending_requests.push_back(req);
    endfunction

    // Returns at a falling edge once nothing is queued, presented or awaited.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        // Bits above the register width are junk that the block must drop.
        pwdata <= ($urandom() & ~APB_W'(CNT_MAX[CAP_W-1:0])) | APB_W'(cap);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity_reg = cap;
    endtask

    // Input beats are predicted when taken; result beats are checked in order.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            req_taken <= i_rst_n && i_in_valid && !o_in_stall;
            if (i_rst_n && i_in_valid && !o_in_stall)
                expected_replies.push_back(predict_reply(i_in_data));
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual hit %0b value %0d",
                             $time, o_out_data.hit, o_out_data.read_value);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out_data.hit !== want.hit) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, want.hit, o_out_data.hit);
                        errors++;
                    end
                    if (o_out_data.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, o_out_data.read_value);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (!i_in_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool [KEY_POOL];
        logic [CAP_W-1:0] phase_caps [PHASES];
        logic [KEY_W-1:0] key;
        int               limit;
        int               span;
        int               phase;
        int               n;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (shadow_valid[i])
            shadow_valid[i] = 1'b0;
        next_stamp = '0;
        held = 0;
        capacity_reg = CAP_RESET;
        send_idle_pct = 25;
        recv_idle_pct = 51;

        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;
        // Going from oversized straight to 4 leaves the store far above capacity.
        phase_caps = '{5'd31, 5'd4, 5'd0, 5'd1, 5'd17, 5'd2, 5'd16, 5'd3, 5'd9};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Misses on an empty store, extreme keys and values, and a stored -1
        // that must come back as a hit.
        queue_item(FUNC_GET, 32'h0000_0000, 32'h0);
        queue_item(FUNC_GET, 32'h8000_0000, 32'h0);
        queue_item(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_item(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_item(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
        queue_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        queue_item(FUNC_PUT, 32'h8000_0000, 32'h1234_5678);
        queue_item(FUNC_GET, 32'h8000_0000, 32'h0);
        // Fill the store, then force out the least used and oldest entry.
        for (n = 0; n < 12; n++)
            queue_item(FUNC_PUT, 32'(100 + n), $urandom());
        queue_item(FUNC_PUT, 32'd200, $urandom());
        queue_item(FUNC_GET, 32'h0000_0000, 32'h0);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_until_drained();
            set_capacity(phase_caps[phase]);
            @(posedge i_clk);
            case (phase / 3)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            limit = (phase_caps[phase] > ENTRIES) ? ENTRIES : int'(phase_caps[phase]);
            // Keep the key set a little larger than the store so that hits,
            // misses and evictions all stay frequent.
            span = (limit + 3 < KEY_POOL - 1) ? limit + 3 : KEY_POOL - 1;
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, span)];
                else
                    key = $urandom();
                queue_item(($urandom_range(0, 1) == 1) ? FUNC_PUT : FUNC_GET, key, $urandom());
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
